// File: rtl/hbed_pkg.sv
// Package: sizes, codes and beat types for the Huffman build/encode/decode unit.
`timescale 1ns / 1ps
`default_nettype none
package hbed_pkg;

  localparam int ALPHA      = 256;
  localparam int NODES      = 2 * ALPHA - 1;
  localparam int MERGED     = NODES - ALPHA;
  localparam int MAX_LEN    = 32;
  localparam int CNT_W      = 16;
  localparam int SYM_W      = 8;
  localparam int NODE_W     = 9;
  localparam int MIDX_W     = 8;
  localparam int WGT_W      = CNT_W + SYM_W;
  localparam int CODE_W     = 32;
  localparam int LEN_W      = 6;
  localparam int PLEN_W     = 9;
  localparam int DIST_W     = 9;

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [NODE_W-1:0] FIRST_MRG = NODE_W'(ALPHA);
  localparam logic [NODE_W-1:0] LAST_LEAF = NODE_W'(ALPHA - 1);

  localparam logic [2:0] CMD_COUNT  = 3'd0;
  localparam logic [2:0] CMD_BUILD  = 3'd1;
  localparam logic [2:0] CMD_ENCODE = 3'd2;
  localparam logic [2:0] CMD_DECODE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CODE   = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;
  localparam logic [1:0] ST_SATURATED = 2'd3;

  typedef struct packed {
    logic [2:0]       command;
    logic [SYM_W-1:0] symbol;
    logic             code_bit_in;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        status;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic [SYM_W-1:0]  decoded_symbol;
    logic [DIST_W-1:0] distinct_symbols;
  } out_beat_t;

endpackage
`default_nettype wire

// File: rtl/hbed_ifs.sv
// Interfaces: command and result channels.
`timescale 1ns / 1ps
`default_nettype none
interface hbed_in_if import hbed_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hbed_out_if import hbed_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/huffman_build_encode_decode_unit.sv
// Top level: static Huffman histogram, tree build, encoder and decoder.
//
//  channel | dir | beat
//  req     | in  | command, symbol, code_bit_in
//  rsp     | out | kind, status, code_bits, code_length, decoded_symbol,
//          |     | distinct_symbols
//
// Clear completes in idle; count and a decode step to an interior node take
// one registered memory read; encode, a decode step to a leaf and a saturated
// count take it and then the result register; encode or decode before a build
// only the result register. Build sweeps the histogram, then per merge scans
// every node below the next index through the single weight-memory port,
// then walks merged nodes and writes the code table.
// Synchronous reset clears control state and histogram valid bits only.
// req.ready is low while busy or while a result is pending for rsp.
`timescale 1ns / 1ps
`default_nettype none
module huffman_build_encode_decode_unit import hbed_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  hbed_in_if.sink    req,
  hbed_out_if.source rsp
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_CNT      = 15'h0002,
    S_ENC      = 15'h0004,
    S_DEC      = 15'h0008,
    S_INIT_RD  = 15'h0010,
    S_INIT_WR  = 15'h0020,
    S_CHK      = 15'h0040,
    S_SCAN_RD  = 15'h0080,
    S_SCAN_CMP = 15'h0100,
    S_MERGE    = 15'h0200,
    S_PATH_RD  = 15'h0400,
    S_PATH_L   = 15'h0800,
    S_PATH_R   = 15'h1000,
    S_CODE_RD  = 15'h2000,
    S_CODE_WR  = 15'h4000
  } state_t;

  state_t state;
  logic   emit_pend;

  // memories
  logic [CNT_W-1:0]           hist_mem [ALPHA];
  logic [ALPHA-1:0]           hist_valid;
  logic [WGT_W-1:0]           wgt_mem  [NODES];
  logic [2*NODE_W-1:0]        kid_mem  [MERGED];
  logic [CODE_W+PLEN_W-1:0]   path_mem [NODES];
  logic [CODE_W+LEN_W-1:0]    code_mem [ALPHA];

  logic [CNT_W-1:0]         hist_q;
  logic                     hv_q;
  logic [WGT_W-1:0]         wgt_q;
  logic [2*NODE_W-1:0]      kid_q;
  logic [CODE_W+PLEN_W-1:0] path_q;
  logic [CODE_W+LEN_W-1:0]  code_q;

  // working registers
  logic [SYM_W-1:0]  sym_q;
  logic              bit_q;
  logic [NODE_W-1:0] idx;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] root;
  logic [NODE_W-1:0] dpos;
  logic              tree_ready;
  logic [DIST_W-1:0] distinct;
  logic [SYM_W-1:0]  leaf;
  logic [NODES-1:0]  live;
  logic [NODE_W-1:0] na, nb;
  logic [WGT_W-1:0]  wa, wb;
  logic              have_a, have_b;
  out_beat_t         res;

  // address and write-port selection
  logic [SYM_W-1:0]         hist_addr;
  logic [MIDX_W-1:0]        kid_raddr;
  logic [NODE_W-1:0]        pos_eff;
  logic                     path_we;
  logic [NODE_W-1:0]        path_waddr;
  logic [CODE_W+PLEN_W-1:0] path_wdata;
  logic                     wgt_we;
  logic [NODE_W-1:0]        wgt_waddr;
  logic [WGT_W-1:0]         wgt_wdata;
  logic                     kid_we;
  logic [MIDX_W-1:0]        kid_waddr;
  logic [2*NODE_W-1:0]      kid_wdata;

  logic [CODE_W-1:0] pc;
  logic [PLEN_W-1:0] pl;
  logic [CNT_W-1:0]  cur_cnt;
  logic [NODE_W-1:0] dec_nxt;

  assign req.ready = (state == S_IDLE) && !emit_pend;
  assign pc        = path_q[CODE_W+PLEN_W-1:PLEN_W];
  assign pl        = path_q[PLEN_W-1:0];
  assign cur_cnt   = hv_q ? hist_q : '0;
  assign dec_nxt   = bit_q ? kid_q[NODE_W-1:0] : kid_q[2*NODE_W-1:NODE_W];
  assign pos_eff   = (dpos < FIRST_MRG || dpos == NODE_W'(NODES)) ? root : dpos;

  always_comb begin
    hist_addr  = (state == S_IDLE) ? req.data.symbol : idx[SYM_W-1:0];
    kid_raddr  = (state == S_IDLE) ? MIDX_W'(pos_eff - FIRST_MRG)
                                   : MIDX_W'(idx - FIRST_MRG);
    path_we    = 1'b0;
    path_waddr = idx;
    path_wdata = '0;
    wgt_we     = 1'b0;
    wgt_waddr  = idx;
    wgt_wdata  = {{SYM_W{1'b0}}, cur_cnt};
    kid_we     = 1'b0;
    kid_waddr  = MIDX_W'(next_node - FIRST_MRG);
    kid_wdata  = {na, nb};
    case (state)
      S_INIT_WR: wgt_we = 1'b1;
      S_CHK: begin
        if (distinct == DIST_W'(1)) begin
          path_we    = 1'b1;
          path_waddr = {1'b0, leaf};
          path_wdata = {{CODE_W{1'b0}}, PLEN_W'(1)};
          kid_we     = 1'b1;
          kid_waddr  = '0;
          kid_wdata  = {{1'b0, leaf}, {1'b0, leaf}};
        end
      end
      S_MERGE: begin
        if (!have_b) begin
          path_we    = 1'b1;
          path_waddr = na;
          path_wdata = '0;
        end else begin
          kid_we    = 1'b1;
          wgt_we    = 1'b1;
          wgt_waddr = next_node;
          wgt_wdata = wa + wb;
        end
      end
      S_PATH_L: begin
        path_we    = 1'b1;
        path_waddr = kid_q[2*NODE_W-1:NODE_W];
        path_wdata = {pc << 1, pl + PLEN_W'(1)};
      end
      S_PATH_R: begin
        path_we    = 1'b1;
        path_waddr = kid_q[NODE_W-1:0];
        path_wdata = {(pc << 1) | CODE_W'(1), pl + PLEN_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    hist_q <= hist_mem[hist_addr];
    hv_q   <= hist_valid[hist_addr];
    wgt_q  <= wgt_mem[idx];
    kid_q  <= kid_mem[kid_raddr];
    path_q <= path_mem[idx];
    code_q <= code_mem[req.data.symbol];
    if (state == S_CNT && cur_cnt != CNT_MAX) begin
      hist_mem[sym_q] <= cur_cnt + CNT_W'(1);
    end
    if (wgt_we) begin
      wgt_mem[wgt_waddr] <= wgt_wdata;
    end
    if (kid_we) begin
      kid_mem[kid_waddr] <= kid_wdata;
    end
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    if (state == S_CODE_WR) begin
      if (wgt_q != '0 && pl <= PLEN_W'(MAX_LEN)) begin
        code_mem[idx[SYM_W-1:0]] <= {pc, pl[LEN_W-1:0]};
      end else begin
        code_mem[idx[SYM_W-1:0]] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      emit_pend  <= 1'b0;
      rsp.valid  <= 1'b0;
      hist_valid <= '0;
      tree_ready <= 1'b0;
      dpos       <= '0;
      root       <= '0;
      res        <= '0;
    end else begin
      // result register cleared on hand-off, so every beat starts from zero
      if (emit_pend && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
        rsp.data  <= res;
        res       <= '0;
        emit_pend <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            sym_q <= req.data.symbol;
            bit_q <= req.data.code_bit_in;
            case (req.data.command)
              CMD_COUNT: state <= S_CNT;
              CMD_BUILD: begin
                live     <= '0;
                idx      <= '0;
                distinct <= '0;
                state    <= S_INIT_RD;
              end
              CMD_ENCODE: begin
                if (!tree_ready) begin
                  res.kind   <= KIND_CODE;
                  res.status <= ST_NOT_BUILT;
                  emit_pend  <= 1'b1;
                end else begin
                  state <= S_ENC;
                end
              end
              CMD_DECODE: begin
                if (!tree_ready) begin
                  res.kind   <= KIND_SYMBOL;
                  res.status <= ST_NOT_BUILT;
                  emit_pend  <= 1'b1;
                end else begin
                  state <= S_DEC;
                end
              end
              CMD_CLEAR: hist_valid <= '0;
              default: ;
            endcase
          end
        end
        S_CNT: begin
          if (cur_cnt == CNT_MAX) begin
            res.kind   <= KIND_STATUS;
            res.status <= ST_SATURATED;
            emit_pend  <= 1'b1;
          end else begin
            hist_valid[sym_q] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_ENC: begin
          res.kind        <= KIND_CODE;
          res.status      <= ST_OK;
          res.code_bits   <= code_q[CODE_W+LEN_W-1:LEN_W];
          res.code_length <= code_q[LEN_W-1:0];
          emit_pend       <= 1'b1;
          state           <= S_IDLE;
        end
        S_DEC: begin
          if (dec_nxt < FIRST_MRG) begin
            dpos               <= root;
            res.kind           <= KIND_SYMBOL;
            res.status         <= ST_OK;
            res.decoded_symbol <= dec_nxt[SYM_W-1:0];
            emit_pend          <= 1'b1;
          end else begin
            dpos <= dec_nxt;
          end
          state <= S_IDLE;
        end
        S_INIT_RD: state <= S_INIT_WR;
        S_INIT_WR: begin
          if (cur_cnt != '0) begin
            live[idx] <= 1'b1;
            distinct  <= distinct + DIST_W'(1);
            leaf      <= idx[SYM_W-1:0];
          end
          if (idx == LAST_LEAF) begin
            state <= S_CHK;
          end else begin
            idx   <= idx + NODE_W'(1);
            state <= S_INIT_RD;
          end
        end
        S_CHK: begin
          idx       <= '0;
          next_node <= FIRST_MRG;
          have_a    <= 1'b0;
          have_b    <= 1'b0;
          if (distinct == '0) begin
            tree_ready <= 1'b0;
            res.kind   <= KIND_STATUS;
            res.status <= ST_EMPTY;
            emit_pend  <= 1'b1;
            state      <= S_IDLE;
          end else if (distinct == DIST_W'(1)) begin
            root  <= FIRST_MRG;
            state <= S_CODE_RD;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx == next_node) begin
            state <= S_MERGE;
          end else if (!live[idx]) begin
            idx <= idx + NODE_W'(1);
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (!have_a || wgt_q < wa) begin
            nb     <= na;
            wb     <= wa;
            have_b <= have_a;
            na     <= idx;
            wa     <= wgt_q;
            have_a <= 1'b1;
          end else if (!have_b || wgt_q < wb) begin
            nb     <= idx;
            wb     <= wgt_q;
            have_b <= 1'b1;
          end
          idx   <= idx + NODE_W'(1);
          state <= S_SCAN_RD;
        end
        S_MERGE: begin
          if (!have_b) begin
            root  <= na;
            idx   <= na;
            state <= S_PATH_RD;
          end else begin
            live[na]        <= 1'b0;
            live[nb]        <= 1'b0;
            live[next_node] <= 1'b1;
            next_node       <= next_node + NODE_W'(1);
            idx             <= '0;
            have_a          <= 1'b0;
            have_b          <= 1'b0;
            state           <= S_SCAN_RD;
          end
        end
        S_PATH_RD: state <= S_PATH_L;
        S_PATH_L:  state <= S_PATH_R;
        S_PATH_R: begin
          if (idx == FIRST_MRG) begin
            idx   <= '0;
            state <= S_CODE_RD;
          end else begin
            idx   <= idx - NODE_W'(1);
            state <= S_PATH_RD;
          end
        end
        S_CODE_RD: state <= S_CODE_WR;
        S_CODE_WR: begin
          if (idx == LAST_LEAF) begin
            dpos                 <= root;
            tree_ready           <= 1'b1;
            res.kind             <= KIND_STATUS;
            res.status           <= ST_OK;
            res.distinct_symbols <= distinct;
            emit_pend            <= 1'b1;
            state                <= S_IDLE;
          end else begin
            idx   <= idx + NODE_W'(1);
            state <= S_CODE_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/huffman_build_encode_decode_unit_tb.sv
// Testbench: Huffman unit driven with directed and random beats, checked against a built-in model.
`timescale 1ns / 1ps
`default_nettype none
module huffman_build_encode_decode_unit_tb;
  import hbed_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    in_beat_t beat;
    bit       hurry;
  } req_item_t;

  logic clk;
  logic rst;

  hbed_in_if  req ();
  hbed_out_if rsp ();

  huffman_build_encode_decode_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  // model state
  int unsigned hist [ALPHA];
  int unsigned wgt [NODES];
  int          lchild [NODES];
  int          rchild [NODES];
  bit          live [NODES];
  int unsigned pcode [NODES];
  int          plen [NODES];
  int unsigned codeword [ALPHA];
  int          codelen [ALPHA];
  int          walk_pos;
  int          root_idx;
  bit          tree_built;

  req_item_t pending [$];
  out_beat_t expected [$];

  int  fails;
  int  cycles;
  int  accepted;
  int  seen [3];
  int  send_gap;
  int  recv_gap;
  bit  req_took;
  bit  rsp_took;

  function automatic int take_lightest(input int upto);
    int best;
    best = -1;
    for (int i = 0; i < upto; i++)
      if (live[i] && (best < 0 || wgt[i] < wgt[best])) best = i;
    if (best >= 0) live[best] = 0;
    return best;
  endfunction

  function automatic int build_codes();
    int distinct;
    int nxt;
    int a;
    int b;
    distinct = 0;
    nxt = ALPHA;
    foreach (live[i]) live[i] = 0;
    foreach (codelen[i]) begin
      codelen[i] = 0;
      codeword[i] = 0;
    end
    for (int i = 0; i < ALPHA; i++) begin
      wgt[i] = hist[i];
      if (hist[i] != 0) begin
        live[i] = 1;
        distinct++;
      end
    end
    if (distinct == 0) begin
      tree_built = 0;
      return 0;
    end
    if (distinct == 1) begin
      a = take_lightest(ALPHA);
      lchild[nxt] = a;
      rchild[nxt] = a;
      wgt[nxt] = wgt[a];
      codeword[a] = 0;
      codelen[a] = 1;
      root_idx = nxt;
    end else begin
      forever begin
        a = take_lightest(nxt);
        b = take_lightest(nxt);
        if (b < 0) begin
          root_idx = a;
          break;
        end
        lchild[nxt] = a;
        rchild[nxt] = b;
        wgt[nxt] = wgt[a] + wgt[b];
        live[nxt] = 1;
        nxt++;
      end
      pcode[root_idx] = 0;
      plen[root_idx] = 0;
      for (int i = root_idx; i >= ALPHA; i--) begin
        pcode[lchild[i]] = pcode[i] << 1;
        plen[lchild[i]] = plen[i] + 1;
        pcode[rchild[i]] = (pcode[i] << 1) | 1;
        plen[rchild[i]] = plen[i] + 1;
      end
      for (int i = 0; i < ALPHA; i++)
        if (hist[i] != 0 && plen[i] <= MAX_LEN) begin
          codeword[i] = pcode[i];
          codelen[i] = plen[i];
        end
    end
    walk_pos = root_idx;
    tree_built = 1;
    return distinct;
  endfunction

  task automatic predict_beat(input in_beat_t b);
    out_beat_t r;
    int pos;
    int nxt;
    int d;
    r = '0;
    case (b.command)
      CMD_COUNT: begin
        if (hist[b.symbol] >= CNT_MAX) begin
          r.kind = KIND_STATUS;
          r.status = ST_SATURATED;
          expected.insert(expected.size(), r);
        end else begin
          hist[b.symbol]++;
        end
      end
      CMD_BUILD: begin
        d = build_codes();
        r.kind = KIND_STATUS;
        r.status = (d == 0) ? ST_EMPTY : ST_OK;
        r.distinct_symbols = DIST_W'(d);
        expected.insert(expected.size(), r);
      end
      CMD_ENCODE: begin
        r.kind = KIND_CODE;
        if (!tree_built) begin
          r.status = ST_NOT_BUILT;
        end else begin
          r.code_bits = codeword[b.symbol];
          r.code_length = LEN_W'(codelen[b.symbol]);
        end
        expected.insert(expected.size(), r);
      end
      CMD_DECODE: begin
        r.kind = KIND_SYMBOL;
        if (!tree_built) begin
          r.status = ST_NOT_BUILT;
          expected.insert(expected.size(), r);
        end else begin
          pos = (walk_pos < ALPHA || walk_pos >= NODES) ? root_idx : walk_pos;
          nxt = b.code_bit_in ? rchild[pos] : lchild[pos];
          if (nxt < ALPHA) begin
            walk_pos = root_idx;
            r.decoded_symbol = SYM_W'(nxt);
            expected.insert(expected.size(), r);
          end else begin
            walk_pos = nxt;
          end
        end
      end
      CMD_CLEAR: foreach (hist[i]) hist[i] = 0;
      default: ;
    endcase
  endtask

  task automatic add(input logic [2:0] cmd, input int sym = 0, input bit cbit = 0,
                     input bit hurry = 0);
    req_item_t it;
    it.beat.command = cmd;
    it.beat.symbol = SYM_W'(sym);
    it.beat.code_bit_in = cbit;
    it.hurry = hurry;
    pending.insert(pending.size(), it);
  endtask

  task automatic add_sequence();
    int pool [$];
    int n;
    int width;
    width = int'($urandom_range(1, 24));
    for (int i = 0; i < width; i++) pool.insert(pool.size(), int'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) != 0) add(CMD_CLEAR);
    n = int'($urandom_range(1, 40));
    for (int i = 0; i < n; i++) add(CMD_COUNT, pool[$urandom_range(0, width - 1)]);
    add(CMD_BUILD);
    n = int'($urandom_range(3, 25));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2:    add(CMD_ENCODE, pool[$urandom_range(0, width - 1)]);
        3:          add(CMD_ENCODE, int'($urandom_range(0, 255)));
        4, 5, 6, 7: add(CMD_DECODE, 0, 1'($urandom_range(0, 1)));
        8:          add(CMD_COUNT, int'($urandom_range(0, 255)));
        default:    add(3'($urandom_range(4, 7)), int'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
      endcase
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    req.valid = 0;
    req.data = '0;
    rsp.ready = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
  end

  // directed part, then random sequences
  initial begin
    add(CMD_ENCODE, 5);
    add(CMD_DECODE, 0, 1);
    add(CMD_BUILD);
    add(CMD_COUNT, 0);
    add(CMD_BUILD);
    add(CMD_ENCODE, 0);
    add(CMD_ENCODE, 255);
    add(CMD_DECODE, 0, 0);
    add(CMD_DECODE, 0, 1);
    add(3'd5, 255, 1);
    add(3'd6, 0, 0);
    add(3'd7, 128, 1);
    repeat (3) add(CMD_COUNT, 255);
    add(CMD_COUNT, 128);
    add(CMD_COUNT, 128);
    add(CMD_BUILD);
    add(CMD_ENCODE, 0);
    add(CMD_ENCODE, 255);
    add(CMD_ENCODE, 128);
    add(CMD_DECODE, 0, 1);
    add(CMD_DECODE, 0, 0);
    add(CMD_DECODE, 0, 1);
    add(CMD_CLEAR);
    add(CMD_ENCODE, 255);
    add(CMD_BUILD);
    add(CMD_DECODE, 0, 0);
    for (int s = 0; s < 12; s++) begin
      add_sequence();
      if (s == 7) begin
        // two equal-weight symbols
        add(CMD_CLEAR);
        add(CMD_COUNT, 200);
        add(CMD_COUNT, 17);
        add(CMD_BUILD);
        add(CMD_ENCODE, 200);
        add(CMD_ENCODE, 17);
        add(CMD_DECODE, 0, 0);
        add(CMD_DECODE, 0, 1);
      end
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    req_took = 0;
    rsp_took = 0;
    if (!rst) begin
      cycles++;
      if (req.valid && req.ready) begin
        req_took = 1;
        accepted++;
        predict_beat(req.data);
      end
      if (rsp.valid && rsp.ready) begin
        out_beat_t want;
        rsp_took = 1;
        if (rsp.data.kind <= KIND_SYMBOL) seen[rsp.data.kind]++;
        if (expected.size() == 0) begin
          $error("unexpected result beat kind=%0d", rsp.data.kind);
          fails++;
        end else begin
          want = expected.pop_front();
          if (rsp.data.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp.data.kind);
            fails++;
          end
          if (rsp.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.data.status);
            fails++;
          end
          if (rsp.data.code_bits !== want.code_bits) begin
            $error("code_bits: expected %h, got %h", want.code_bits, rsp.data.code_bits);
            fails++;
          end
          if (rsp.data.code_length !== want.code_length) begin
            $error("code_length: expected %0d, got %0d", want.code_length,
                   rsp.data.code_length);
            fails++;
          end
          if (rsp.data.decoded_symbol !== want.decoded_symbol) begin
            $error("decoded_symbol: expected %0d, got %0d", want.decoded_symbol,
                   rsp.data.decoded_symbol);
            fails++;
          end
          if (rsp.data.distinct_symbols !== want.distinct_symbols) begin
            $error("distinct_symbols: expected %0d, got %0d", want.distinct_symbols,
                   rsp.data.distinct_symbols);
            fails++;
          end
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("huffman_build_encode_decode_unit: mismatch");
        $finish;
      end
    end
  end

  // command driver
  always @(negedge clk) begin
    if (!rst && (!req.valid || req_took)) begin
      if (send_gap > 0 || pending.size() == 0) begin
        if (send_gap > 0) send_gap--;
        req.valid <= 0;
      end else begin
        req_item_t it;
        it = pending.pop_front();
        req.data <= it.beat;
        req.valid <= 1;
        send_gap = (it.hurry || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_took) recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (recv_gap > 0) begin
        recv_gap--;
        rsp.ready <= 0;
      end else begin
        rsp.ready <= 1;
      end
    end
  end

  initial begin
    @(negedge rst);
    do @(posedge clk);
    while (pending.size() != 0 || req.valid || expected.size() != 0);
    repeat (50) @(posedge clk);
    $display("%0d command beats taken over %0d cycles", accepted, cycles);
    $display("results seen: %0d status, %0d code, %0d symbol", seen[0], seen[1], seen[2]);
    if (fails == 0 && expected.size() == 0)
      $display("huffman_build_encode_decode_unit: match");
    else
      $display("huffman_build_encode_decode_unit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
